FILE: rtl/lqr_pkg.sv
// Shared types, constants and helpers for the LQR state-feedback controller.
// Used by lqr_integral_state_feedback; no dependencies.
`timescale 1ns / 1ps

package lqr_pkg;

    localparam int DATA_W           = 32;
    localparam int NUM_PLANT_STATES = 4;
    localparam int S_DATA_W         = (NUM_PLANT_STATES + 1) * DATA_W;
    localparam int ACC_W            = 67;   // five exact 64-bit products plus headroom
    localparam int FRAC_BITS_DEF    = 16;
    localparam int NUM_REGS         = 8;
    localparam int PADDR_W          = 5;

    // Register indexes
    localparam logic [2:0] REG_GAIN_POS    = 3'd0;
    localparam logic [2:0] REG_GAIN_ANGLE  = 3'd1;
    localparam logic [2:0] REG_GAIN_VEL    = 3'd2;
    localparam logic [2:0] REG_GAIN_RATE   = 3'd3;
    localparam logic [2:0] REG_GAIN_INTEG  = 3'd4;
    localparam logic [2:0] REG_INTEG_STEP  = 3'd5;
    localparam logic [2:0] REG_INTEG_DECAY = 3'd6;
    localparam logic [2:0] REG_REF_SCALE   = 3'd7;

    // Register reset values
    localparam logic [DATA_W-1:0] RST_GAIN_POS    = 32'd32494;
    localparam logic [DATA_W-1:0] RST_GAIN_ANGLE  = 32'd2543865;
    localparam logic [DATA_W-1:0] RST_GAIN_VEL    = 32'd38561;
    localparam logic [DATA_W-1:0] RST_GAIN_RATE   = 32'd493814;
    localparam logic [DATA_W-1:0] RST_GAIN_INTEG  = 32'd11895;
    localparam logic [DATA_W-1:0] RST_INTEG_STEP  = 32'd328;
    localparam logic [DATA_W-1:0] RST_INTEG_DECAY = 32'd65536;
    localparam logic [DATA_W-1:0] RST_REF_SCALE   = 32'd65536;

    // Multiply schedule, one product per step
    localparam logic [2:0] STEP_REF    = 3'd0;  // ref_scale * reference
    localparam logic [2:0] STEP_ANGLE  = 3'd1;  // gain_angle * meas_angle
    localparam logic [2:0] STEP_VEL    = 3'd2;  // gain_vel * meas_vel
    localparam logic [2:0] STEP_RATE   = 3'd3;  // gain_rate * meas_rate
    localparam logic [2:0] STEP_ZGAIN  = 3'd4;  // gain_integ * z_old
    localparam logic [2:0] STEP_ZDECAY = 3'd5;  // integ_decay * z_old
    localparam logic [2:0] STEP_EPOS   = 3'd6;  // gain_pos * e1
    localparam logic [2:0] STEP_ESTEP  = 3'd7;  // integ_step * e1
    localparam logic [3:0] RUN_STEPS   = 4'd8;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_FIN
    } lqr_state_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] val;
        logic                     clip;
    } sat_t;

    // Clamp a wide signed value to 32 bits and flag a clip
    function automatic sat_t sat32(input logic signed [ACC_W-1:0] v);
        sat_t r;
        if ((&v[ACC_W-1:DATA_W-1]) || !(|v[ACC_W-1:DATA_W-1])) begin
            r.val  = v[DATA_W-1:0];
            r.clip = 1'b0;
        end else begin
            r.val  = v[ACC_W-1] ? {1'b1, {(DATA_W-1){1'b0}}} : {1'b0, {(DATA_W-1){1'b1}}};
            r.clip = 1'b1;
        end
        return r;
    endfunction

endpackage

FILE: rtl/lqr_integral_state_feedback.sv
// LQR state feedback with integral action: one shared 32x32 multiplier stepped
// by a small sequencer. An item takes 8 multiplier issues, a drain and a rounding
// step; the next item is accepted only after its result is loaded into the output
// register, a load that can stall on m_tready. A finished result waits there while
// the next item is accepted. Synchronous active-low aresetn restores the register
// reset values and clears the integrator and both channels; uses lqr_pkg.
`timescale 1ns / 1ps

module lqr_integral_state_feedback
    import lqr_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  logic                aclk,
    input  logic                aresetn,
    // input items
    input  logic                s_tvalid,
    output logic                s_tready,
    // meas_pos[31:0], meas_angle[63:32], meas_vel[95:64], meas_rate[127:96],
    // reference[159:128]
    input  logic [S_DATA_W-1:0] s_tdata,
    // result items
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [DATA_W-1:0]   m_tdata,   // drive[31:0]
    output logic                m_tuser,   // saturated[0]
    // configuration
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [PADDR_W-1:0]  paddr,
    input  logic [DATA_W-1:0]   pwdata,
    output logic [DATA_W-1:0]   prdata,
    output logic                pready
);

    localparam logic signed [ACC_W-1:0] HALF = ACC_W'(1) <<< (FRAC_BITS - 1);

    // Configuration registers
    logic signed [DATA_W-1:0] gain_pos_reg, gain_angle_reg, gain_vel_reg, gain_rate_reg;
    logic signed [DATA_W-1:0] gain_integ_reg, integ_step_reg, integ_decay_reg, ref_scale_reg;

    // Datapath registers
    logic signed [DATA_W-1:0] meas_pos_reg, meas_angle_reg, meas_vel_reg, meas_rate_reg;
    logic signed [DATA_W-1:0] reference_reg, integ_reg, e1_reg;
    logic signed [2*DATA_W-1:0] prod_reg;
    logic [2:0]               prod_tag_reg;
    logic                     prod_vld_reg;
    logic signed [ACC_W-1:0]  acc_drive_reg, acc_integ_reg;
    logic                     clip_reg;
    logic [3:0]               step_reg;
    lqr_state_t               state_reg, state_next;
    logic                     m_tvalid_reg, m_tuser_reg;
    logic [DATA_W-1:0]        m_tdata_reg;

    logic                     cfg_wr, in_fire, issue, fin_fire;
    logic signed [DATA_W-1:0] mul_a, mul_b;
    logic signed [2*DATA_W-1:0] prod_next;
    logic signed [ACC_W-1:0]  prod_ext, e1_wide;
    sat_t                     e1_sat, drive_sat, integ_sat;

    assign pready   = 1'b1;
    assign cfg_wr   = psel & penable & pwrite & pready;
    assign s_tready = (state_reg == ST_IDLE);
    assign in_fire  = s_tvalid & s_tready;
    assign issue    = (state_reg == ST_RUN) && (step_reg < RUN_STEPS);
    assign fin_fire = (state_reg == ST_FIN) && (!m_tvalid_reg || m_tready);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    // Register writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            gain_pos_reg    <= RST_GAIN_POS;
            gain_angle_reg  <= RST_GAIN_ANGLE;
            gain_vel_reg    <= RST_GAIN_VEL;
            gain_rate_reg   <= RST_GAIN_RATE;
            gain_integ_reg  <= RST_GAIN_INTEG;
            integ_step_reg  <= RST_INTEG_STEP;
            integ_decay_reg <= RST_INTEG_DECAY;
            ref_scale_reg   <= RST_REF_SCALE;
        end else if (cfg_wr) begin
            case (paddr[PADDR_W-1:2])
                REG_GAIN_POS:    gain_pos_reg    <= pwdata;
                REG_GAIN_ANGLE:  gain_angle_reg  <= pwdata;
                REG_GAIN_VEL:    gain_vel_reg    <= pwdata;
                REG_GAIN_RATE:   gain_rate_reg   <= pwdata;
                REG_GAIN_INTEG:  gain_integ_reg  <= pwdata;
                REG_INTEG_STEP:  integ_step_reg  <= pwdata;
                REG_INTEG_DECAY: integ_decay_reg <= pwdata;
                REG_REF_SCALE:   ref_scale_reg   <= pwdata;
                default:         ;
            endcase
        end
    end

    // Register reads
    always_comb begin
        case (paddr[PADDR_W-1:2])
            REG_GAIN_POS:    prdata = gain_pos_reg;
            REG_GAIN_ANGLE:  prdata = gain_angle_reg;
            REG_GAIN_VEL:    prdata = gain_vel_reg;
            REG_GAIN_RATE:   prdata = gain_rate_reg;
            REG_GAIN_INTEG:  prdata = gain_integ_reg;
            REG_INTEG_STEP:  prdata = integ_step_reg;
            REG_INTEG_DECAY: prdata = integ_decay_reg;
            REG_REF_SCALE:   prdata = ref_scale_reg;
            default:         prdata = '0;
        endcase
    end

    // Select multiplier operands for the current step
    always_comb begin
        case (step_reg[2:0])
            STEP_REF:    begin mul_a = ref_scale_reg;   mul_b = reference_reg;  end
            STEP_ANGLE:  begin mul_a = gain_angle_reg;  mul_b = meas_angle_reg; end
            STEP_VEL:    begin mul_a = gain_vel_reg;    mul_b = meas_vel_reg;   end
            STEP_RATE:   begin mul_a = gain_rate_reg;   mul_b = meas_rate_reg;  end
            STEP_ZGAIN:  begin mul_a = gain_integ_reg;  mul_b = integ_reg;      end
            STEP_ZDECAY: begin mul_a = integ_decay_reg; mul_b = integ_reg;      end
            STEP_EPOS:   begin mul_a = gain_pos_reg;    mul_b = e1_reg;         end
            STEP_ESTEP:  begin mul_a = integ_step_reg;  mul_b = e1_reg;         end
            default:     begin mul_a = '0;              mul_b = '0;             end
        endcase
    end

    assign prod_next = mul_a * mul_b;
    assign prod_ext  = ACC_W'(prod_reg);

    // First-state error: measured minus rounded scaled reference, then clamp
    assign e1_wide = ACC_W'(meas_pos_reg) - ((prod_ext + HALF) >>> FRAC_BITS);
    assign e1_sat  = sat32(e1_wide);

    // Round and clamp the two sums
    assign drive_sat = sat32((acc_drive_reg + HALF) >>> FRAC_BITS);
    assign integ_sat = sat32((acc_integ_reg + HALF) >>> FRAC_BITS);

    // State register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (in_fire) state_next = ST_RUN;
            end
            ST_RUN: begin
                if (step_reg == RUN_STEPS) state_next = ST_FIN;
            end
            ST_FIN: begin
                if (fin_fire) state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Sequencer control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_reg     <= '0;
            prod_vld_reg <= 1'b0;
            m_tvalid_reg <= 1'b0;
            integ_reg    <= '0;
        end else begin
            if (in_fire) begin
                step_reg <= '0;
            end else if (issue) begin
                step_reg <= step_reg + 4'd1;
            end
            prod_vld_reg <= issue;
            if (fin_fire) begin
                m_tvalid_reg <= 1'b1;
                integ_reg    <= integ_sat.val;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    // Datapath: latch item, multiply, accumulate, load result
    always_ff @(posedge aclk) begin
        if (in_fire) begin
            meas_pos_reg   <= s_tdata[0*DATA_W +: DATA_W];
            meas_angle_reg <= s_tdata[1*DATA_W +: DATA_W];
            meas_vel_reg   <= s_tdata[2*DATA_W +: DATA_W];
            meas_rate_reg  <= s_tdata[3*DATA_W +: DATA_W];
            reference_reg  <= s_tdata[4*DATA_W +: DATA_W];
            acc_drive_reg  <= '0;
            acc_integ_reg  <= '0;
            clip_reg       <= 1'b0;
        end else if (prod_vld_reg) begin
            case (prod_tag_reg)
                STEP_REF: begin
                    e1_reg   <= e1_sat.val;
                    clip_reg <= clip_reg | e1_sat.clip;
                end
                STEP_ZDECAY, STEP_ESTEP: acc_integ_reg <= acc_integ_reg + prod_ext;
                default:                 acc_drive_reg <= acc_drive_reg + prod_ext;
            endcase
        end
        if (issue) begin
            prod_reg     <= prod_next;
            prod_tag_reg <= step_reg[2:0];
        end
        if (fin_fire) begin
            m_tdata_reg <= drive_sat.val;
            m_tuser_reg <= clip_reg | drive_sat.clip | integ_sat.clip;
        end
    end

    // Checks
    a_accept_starts_run: assert property (@(posedge aclk) disable iff (!aresetn)
        in_fire |=> (state_reg == ST_RUN) && (step_reg == '0))
        else $error("accepted item did not start the multiply sequence");

    a_prod_from_run: assert property (@(posedge aclk) disable iff (!aresetn)
        prod_vld_reg |-> ($past(state_reg) == ST_RUN) && (prod_tag_reg == $past(step_reg[2:0])))
        else $error("product tag out of step with sequencer");

    a_fin_loads_output: assert property (@(posedge aclk) disable iff (!aresetn)
        fin_fire |=> m_tvalid && (state_reg == ST_IDLE))
        else $error("rounding cycle did not load the output register");

    a_busy_not_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != ST_IDLE) |-> !s_tready)
        else $error("input ready while an item is in progress");

    a_integ_reset: assert property (@(posedge aclk)
        !aresetn |=> (integ_reg == '0))
        else $error("integrator not cleared by reset");

endmodule
